@@ hw/rtl/hamming_nearest_descriptor_match_unit_macros.svh @@
// Assertion macros for the Hamming descriptor matcher.
// Used by files that assert; they expect clk and rst_n in scope.
`ifndef HAMMING_NEAREST_DESCRIPTOR_MATCH_UNIT_MACROS_SVH
`define HAMMING_NEAREST_DESCRIPTOR_MATCH_UNIT_MACROS_SVH

// Checked only while the block is out of reset.
`define HNDM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define HNDM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/hndm_pkg.sv @@
// Shared types, constants and popcount helpers for the Hamming descriptor matcher.
// No dependencies; every other file of the block but the macro header imports this package.
`timescale 1ns / 1ps

package hndm_pkg;

  // Table geometry. TABLE_DEPTH must be a multiple of NUM_LANES.
  localparam int TABLE_DEPTH = 1024;
  localparam int NUM_LANES   = 4;
  localparam int LANE_BITS   = $clog2(NUM_LANES);
  localparam int BANK_DEPTH  = TABLE_DEPTH / NUM_LANES;
  localparam int ROW_W       = $clog2(BANK_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Depth of the lane pipeline: bank read, per-word popcount, word sum.
  localparam int LANE_LAT    = 3;

  // Descriptor and field widths.
  localparam int DESC_WORDS = 4;
  localparam int WORD_W     = 64;
  localparam int WCNT_W     = 7;
  localparam int DIST_W     = 9;
  localparam int COORD_W    = 12;
  localparam int ID_W       = 16;
  localparam int REQ_W      = 2;

  localparam logic [DIST_W-1:0] NO_DISTANCE = 9'd511;
  localparam logic [DIST_W-1:0] MAX_DISTANCE = 9'd256;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

  typedef logic [DESC_WORDS-1:0][WORD_W-1:0] desc_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [ID_W-1:0]    id;
  } entry_t;

  typedef struct packed {
    logic [DIST_W-1:0] ham_dist;
    entry_t            entry;
  } lane_res_t;

  // Travels beside a table row through the lane pipeline.
  typedef struct packed {
    logic                 vld;
    logic                 last;
    logic [NUM_LANES-1:0] lane_ok;
  } scan_tag_t;

  function automatic logic [3:0] popcount8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'b000, v[i]};
    end
    return n;
  endfunction

  // Balanced tree: byte counts, then pairs, quads and the final sum.
  function automatic logic [WCNT_W-1:0] popcount64(input logic [63:0] v);
    logic [3:0] c8 [8];
    logic [4:0] c16 [4];
    logic [5:0] c32 [2];
    for (int i = 0; i < 8; i++) begin
      c8[i] = popcount8(v[8*i +: 8]);
    end
    for (int i = 0; i < 4; i++) begin
      c16[i] = {1'b0, c8[2*i]} + {1'b0, c8[2*i+1]};
    end
    for (int i = 0; i < 2; i++) begin
      c32[i] = {1'b0, c16[2*i]} + {1'b0, c16[2*i+1]};
    end
    return {1'b0, c32[0]} + {1'b0, c32[1]};
  endfunction

endpackage

@@ hw/rtl/hndm_chan_if.sv @@
// Valid/ready channel interfaces for the request and result beats.
// Depends on hndm_pkg for field widths.
`timescale 1ns / 1ps

interface hndm_in_if import hndm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [WORD_W-1:0]  desc_word0;
  logic [WORD_W-1:0]  desc_word1;
  logic [WORD_W-1:0]  desc_word2;
  logic [WORD_W-1:0]  desc_word3;
  logic [COORD_W-1:0] point_x;
  logic [COORD_W-1:0] point_y;
  logic [ID_W-1:0]    point_id;

  modport source (
    output valid, req_type, desc_word0, desc_word1, desc_word2, desc_word3,
           point_x, point_y, point_id,
    input  ready
  );
  modport sink (
    input  valid, req_type, desc_word0, desc_word1, desc_word2, desc_word3,
           point_x, point_y, point_id,
    output ready
  );
endinterface

interface hndm_out_if import hndm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] query_x;
  logic [COORD_W-1:0] query_y;
  logic [ID_W-1:0]    query_id;
  logic [COORD_W-1:0] best_x;
  logic [COORD_W-1:0] best_y;
  logic [ID_W-1:0]    best_id;
  logic [DIST_W-1:0]  distance;
  logic               found;

  modport source (
    output valid, query_x, query_y, query_id, best_x, best_y, best_id,
           distance, found,
    input  ready
  );
  modport sink (
    input  valid, query_x, query_y, query_id, best_x, best_y, best_id,
           distance, found,
    output ready
  );
endinterface

@@ hw/rtl/hamming_nearest_descriptor_match_unit.sv @@
// Top level of the brute-force Hamming matcher for 256-bit descriptors.
// Clear and load beats are taken while idle and leave the block idle. A query
// over N stored entries scans ceil(N/4) rows, four lanes at a time (an empty
// table skips the scan), and the next beat is taken once its result beat is
// valid, later while an older result waits.
// rst_n is synchronous: it empties the table and drops any pending result.
`timescale 1ns / 1ps
`include "hamming_nearest_descriptor_match_unit_macros.svh"

module hamming_nearest_descriptor_match_unit import hndm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  hndm_in_if.sink     in_ch,
  hndm_out_if.source  out_ch
);

  // The table is striped across four lanes: entry e lives in lane e mod 4,
  // at row e / 4 of that lane's bank. A query walks the rows in order, one
  // per cycle; each lane compares its entry of the row against the held
  // query descriptor, and the merging stage keeps the first strict minimum.
  // The lane pipeline registers the bank read, the per-word popcount and the
  // word sum, so a tag line of the same depth tells the merger which lanes
  // of a row hold live entries and which row is the last.

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t             state_r;
  logic [CNT_W-1:0]   count_r;
  logic [ROW_W-1:0]   row_r;
  desc_t              qry_desc_r;
  entry_t             qry_ent_r;

  logic               out_valid_r;
  entry_t             out_qry_r;
  entry_t             out_best_r;
  logic [DIST_W-1:0]  out_dist_r;
  logic               out_found_r;

  scan_tag_t          tag_pipe_r [LANE_LAT];
  scan_tag_t          issue_tag;

  logic               in_fire;
  logic               is_load;
  logic               is_query;
  logic               is_clear;
  logic               load_ok;
  logic [ROW_W-1:0]   last_row;
  logic               out_free;

  desc_t              in_desc;
  entry_t             in_entry;
  lane_res_t          lane_res [NUM_LANES];
  lane_res_t          best;
  logic               best_found;
  logic               merge_done;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign is_clear    = in_fire && (in_ch.req_type == REQ_CLEAR);
  assign is_load     = in_fire && (in_ch.req_type == REQ_LOAD);
  assign is_query    = in_fire && (in_ch.req_type == REQ_QUERY);
  // A load into a full table is dropped.
  assign load_ok     = is_load && (count_r < CNT_W'(TABLE_DEPTH));

  assign in_desc  = {in_ch.desc_word3, in_ch.desc_word2, in_ch.desc_word1, in_ch.desc_word0};
  assign in_entry = '{x: in_ch.point_x, y: in_ch.point_y, id: in_ch.point_id};

  // Only meaningful while scanning, when the table holds at least one entry.
  assign last_row = ROW_W'((count_r - CNT_W'(1)) >> LANE_BITS);

  // The result register frees up when empty or when its beat is taken.
  assign out_free = !out_valid_r || out_ch.ready;

  // Tag for the row being issued this cycle: a lane is live when its entry
  // index lies below the fill count.
  always_comb begin
    issue_tag.vld  = (state_r == ST_SCAN);
    issue_tag.last = (row_r == last_row);
    for (int l = 0; l < NUM_LANES; l++) begin
      issue_tag.lane_ok[l] = (CNT_W'({row_r, LANE_BITS'(l)}) < count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < LANE_LAT; s++) begin
        tag_pipe_r[s] <= '0;
      end
    end else begin
      tag_pipe_r[0] <= issue_tag;
      for (int s = 1; s < LANE_LAT; s++) begin
        tag_pipe_r[s] <= tag_pipe_r[s-1];
      end
    end
  end

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    hndm_lane u_lane (
      .clk      (clk),
      .wr_en    (load_ok && (count_r[LANE_BITS-1:0] == LANE_BITS'(l))),
      .wr_row   (count_r[LANE_BITS +: ROW_W]),
      .wr_desc  (in_desc),
      .wr_entry (in_entry),
      .rd_row   (row_r),
      .query    (qry_desc_r),
      .res      (lane_res[l])
    );
  end

  hndm_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (is_query),
    .tag      (tag_pipe_r[LANE_LAT-1]),
    .lane_res (lane_res),
    .best     (best),
    .found    (best_found),
    .done     (merge_done)
  );

  // Sequencer, fill count and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // In the finish state the result register is refilled instead.
      if (out_valid_r && out_ch.ready && (state_r != ST_FINISH)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          row_r <= '0;
          if (is_clear) begin
            count_r <= '0;
          end
          if (load_ok) begin
            count_r <= count_r + CNT_W'(1);
          end
          if (is_query) begin
            qry_desc_r <= in_desc;
            qry_ent_r  <= in_entry;
            // An empty table skips the scan; the merger holds its start values.
            state_r    <= (count_r == '0) ? ST_FINISH : ST_SCAN;
          end
        end
        ST_SCAN: begin
          row_r <= row_r + ROW_W'(1);
          if (row_r == last_row) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (merge_done) begin
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_qry_r   <= qry_ent_r;
            out_best_r  <= best.entry;
            out_dist_r  <= best.ham_dist;
            out_found_r <= best_found;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.query_x  = out_qry_r.x;
  assign out_ch.query_y  = out_qry_r.y;
  assign out_ch.query_id = out_qry_r.id;
  assign out_ch.best_x   = out_best_r.x;
  assign out_ch.best_y   = out_best_r.y;
  assign out_ch.best_id  = out_best_r.id;
  assign out_ch.distance = out_dist_r;
  assign out_ch.found    = out_found_r;

  // The fill count never passes the table depth.
  `HNDM_ASSERT(a_count_bound, count_r <= CNT_W'(TABLE_DEPTH), "fill count beyond table depth")
  // The merger only reports the end of a scan while the sequencer drains.
  `HNDM_ASSERT(a_done_in_drain, merge_done |-> state_r == ST_DRAIN, "merge done outside drain")
  // A miss carries the no-distance code and a hit a real Hamming distance.
  `HNDM_ASSERT(a_miss_dist, out_valid_r && !out_found_r |-> out_dist_r == NO_DISTANCE, "miss with a distance")
  `HNDM_ASSERT(a_hit_dist, out_valid_r && out_found_r |-> out_dist_r <= MAX_DISTANCE, "hit distance out of range")
  // An accepted query starts a scan or goes straight to the result.
  `HNDM_ASSERT(a_query_start, is_query |=> state_r == ST_SCAN || state_r == ST_FINISH, "query did not start")

endmodule

@@ hw/rtl/hndm_lane.sv @@
// One matching lane: a bank of the reference table and a three-stage
// XOR/popcount pipeline. Depends on hndm_pkg.
`timescale 1ns / 1ps

module hndm_lane import hndm_pkg::*; (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [ROW_W-1:0] wr_row,
  input  desc_t            wr_desc,
  input  entry_t           wr_entry,
  input  logic [ROW_W-1:0] rd_row,
  input  desc_t            query,
  output lane_res_t        res
);

  desc_t  desc_mem [BANK_DEPTH];
  entry_t ent_mem  [BANK_DEPTH];

  desc_t             rd_desc_r;
  entry_t            rd_ent_r;
  logic [WCNT_W-1:0] wcnt_r [DESC_WORDS];
  entry_t            cnt_ent_r;
  logic [DIST_W-1:0] dist_r;
  entry_t            dist_ent_r;
  logic [DIST_W-1:0] dist_sum;

  // Bank: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      desc_mem[wr_row] <= wr_desc;
      ent_mem[wr_row]  <= wr_entry;
    end
    rd_desc_r <= desc_mem[rd_row];
    rd_ent_r  <= ent_mem[rd_row];
  end

  always_ff @(posedge clk) begin
    for (int w = 0; w < DESC_WORDS; w++) begin
      wcnt_r[w] <= popcount64(rd_desc_r[w] ^ query[w]);
    end
    cnt_ent_r <= rd_ent_r;
  end

  always_comb begin
    dist_sum = '0;
    for (int w = 0; w < DESC_WORDS; w++) begin
      dist_sum = dist_sum + DIST_W'(wcnt_r[w]);
    end
  end

  always_ff @(posedge clk) begin
    dist_r     <= dist_sum;
    dist_ent_r <= cnt_ent_r;
  end

  assign res.ham_dist = dist_r;
  assign res.entry    = dist_ent_r;

endmodule

@@ hw/rtl/hndm_merge.sv @@
// Merging stage: picks the best lane of a row, then folds it into the running best.
// Depends on hndm_pkg.
`timescale 1ns / 1ps

module hndm_merge import hndm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  scan_tag_t         tag,
  input  lane_res_t         lane_res [NUM_LANES],
  output lane_res_t         best,
  output logic              found,
  output logic              done
);

  lane_res_t cand;
  logic      cand_found;

  lane_res_t cand_r;
  logic      cand_found_r;
  logic      cand_vld_r;
  logic      cand_last_r;
  lane_res_t best_r;
  logic      found_r;
  logic      done_r;

  // Ascending lane order with a strict compare keeps the lowest index on ties.
  always_comb begin
    cand.ham_dist = NO_DISTANCE;
    cand.entry    = '0;
    cand_found    = 1'b0;
    for (int l = 0; l < NUM_LANES; l++) begin
      if (tag.lane_ok[l] && (lane_res[l].ham_dist < cand.ham_dist)) begin
        cand       = lane_res[l];
        cand_found = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_vld_r  <= 1'b0;
      cand_last_r <= 1'b0;
    end else begin
      cand_vld_r  <= tag.vld;
      cand_last_r <= tag.last;
    end
    cand_r       <= cand;
    cand_found_r <= cand_found;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r         <= 1'b0;
      done_r          <= 1'b0;
      best_r.ham_dist <= NO_DISTANCE;
    end else begin
      done_r <= cand_vld_r && cand_last_r;
      if (start) begin
        found_r         <= 1'b0;
        best_r.ham_dist <= NO_DISTANCE;
        best_r.entry    <= '0;
      end else if (cand_vld_r && cand_found_r && (cand_r.ham_dist < best_r.ham_dist)) begin
        found_r <= 1'b1;
        best_r  <= cand_r;
      end
    end
  end

  assign best  = best_r;
  assign found = found_r;
  assign done  = done_r;

endmodule
